### rtl/core/assert_macros.svh
// assertion helper macros for the rtl core
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### rtl/core/dpts_pkg.sv
// shared types and constants of the dynamic priority task scheduler
// no dependencies
package dpts_pkg;

  localparam int MAX_TASKS_DEF = 16;

  // result status codes
  localparam logic [1:0] ST_RAN    = 2'd0;
  localparam logic [1:0] ST_LOADED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_SCAN,
    S_RUN_SCAN,
    S_RUN_TAIL,
    S_RUN_WB
  } state_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [7:0]        id;
    logic [7:0]        rtime;
    logic signed [7:0] prio;
    logic [15:0]       order;
  } entry_t;

  // one result word
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        id;
    logic [7:0]        rtime;
    logic signed [7:0] prio;
    logic              finished;
  } result_t;

endpackage

### rtl/core/dynamic_priority_task_scheduler.sv
// dynamic priority task scheduler with aging: ready table in one memory
// depends on dpts_pkg and assert_macros.svh
//
// Usage: raise start with operation, task_id, run_time and priority_req while
// busy is low; the command is taken at that edge. operation 0 loads a task into
// the lowest free slot, operation 1 runs one slice of the valid task of highest
// priority (earliest loaded among equals), lowering its time and priority by one
// (priority floor -128) and removing it when its time reaches zero.
// Each command gives one result word, shown for exactly one cycle with done high:
// status, selected_id, remaining_time, new_priority, finished. Non-run results
// carry zero fields. The receiver cannot stall; it must take the word on done.
// Sequence: a load checks the valid bits one per cycle from slot 0 until it finds
// a free slot, or reports full when the last slot is also taken.
// A run reads the memory one entry per cycle through a registered read, compares
// each word read against the best so far, then writes back the chosen task. busy is
// low again in the done cycle, so a new command may be taken there.
// Reset clears all valid bits and the load counter at once; no clearing pass.
`include "assert_macros.svh"

module dynamic_priority_task_scheduler
  import dpts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  logic [7:0]        task_id,
  input  logic [7:0]        run_time,
  input  logic signed [7:0] priority_req,
  output logic              busy,
  output logic              done,
  output logic [1:0]        status,
  output logic [7:0]        selected_id,
  output logic [7:0]        remaining_time,
  output logic signed [7:0] new_priority,
  output logic              finished
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

  state_t state, state_next;

  logic [IW-1:0]        idx;
  logic [MAX_TASKS-1:0] valid;
  logic [15:0]          load_counter;

  logic [7:0]        id_q;
  logic [7:0]        time_q;
  logic signed [7:0] prio_q;

  // table memory
  entry_t mem [MAX_TASKS];
  entry_t rd_data;
  logic   rd_live;
  logic   rd_vld;
  logic [IW-1:0] rd_idx;

  // best candidate of the current scan
  logic          best_found;
  logic [IW-1:0] best_idx;
  entry_t        best_entry;
  logic [15:0]   best_age;

  // control from the output decoder
  logic          accept;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          valid_set;
  logic          valid_clr;
  logic          res_load;
  result_t       res_next;

  logic [15:0]       rd_age;
  logic              take;
  logic [7:0]        t_new;
  logic signed [7:0] p_new;

  assign accept = start && !busy;

  // compare the word read in the previous cycle against the best so far
  assign rd_age = load_counter - rd_data.order;
  assign take = rd_live && rd_vld &&
                (!best_found || ($signed(rd_data.prio) > $signed(best_entry.prio)) ||
                 ((rd_data.prio == best_entry.prio) && (rd_age > best_age)));

  // slice update of the chosen task
  assign t_new = (best_entry.rtime == 8'd0) ? 8'd0 : best_entry.rtime - 8'd1;
  assign p_new = (best_entry.prio == -8'sd128) ? -8'sd128 : best_entry.prio - 8'sd1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = operation ? S_RUN_SCAN : S_LOAD_SCAN;
      end
      S_LOAD_SCAN: begin
        if (!valid[idx] || idx == LAST_IDX) state_next = S_IDLE;
      end
      S_RUN_SCAN: begin
        if (idx == LAST_IDX) state_next = S_RUN_TAIL;
      end
      S_RUN_TAIL: state_next = S_RUN_WB;
      S_RUN_WB:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    busy      = (state != S_IDLE);
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_data   = '{id: id_q, rtime: time_q, prio: prio_q, order: load_counter};
    valid_set = 1'b0;
    valid_clr = 1'b0;
    res_load  = 1'b0;
    res_next  = '0;
    case (state)
      S_LOAD_SCAN: begin
        if (!valid[idx]) begin
          wr_en           = 1'b1;
          valid_set       = 1'b1;
          res_load        = 1'b1;
          res_next.status = ST_LOADED;
        end else if (idx == LAST_IDX) begin
          res_load        = 1'b1;
          res_next.status = ST_FULL;
        end
      end
      S_RUN_WB: begin
        res_load = 1'b1;
        if (best_found) begin
          wr_en             = 1'b1;
          wr_addr           = best_idx;
          wr_data           = '{id: best_entry.id, rtime: t_new, prio: p_new,
                                order: best_entry.order};
          valid_clr         = (t_new == 8'd0);
          res_next.status   = ST_RAN;
          res_next.id       = best_entry.id;
          res_next.rtime    = t_new;
          res_next.prio     = p_new;
          res_next.finished = (t_new == 8'd0);
        end else begin
          res_next.status = ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid        <= '0;
      load_counter <= '0;
      rd_live      <= 1'b0;
      best_found   <= 1'b0;
      done         <= 1'b0;
    end else begin
      state   <= state_next;
      rd_live <= (state == S_RUN_SCAN);
      done    <= res_load;
      if (valid_set) begin
        valid[wr_addr] <= 1'b1;
        load_counter   <= load_counter + 16'd1;
      end
      if (valid_clr) valid[wr_addr] <= 1'b0;
      if (accept) best_found <= 1'b0;
      else if (take) best_found <= 1'b1;
    end
  end

  // command word, scan index and best candidate payload
  always_ff @(posedge clk) begin
    if (accept) begin
      id_q   <= task_id;
      time_q <= run_time;
      prio_q <= priority_req;
      idx    <= '0;
    end else if (state == S_LOAD_SCAN || state == S_RUN_SCAN) begin
      idx <= idx + 1'b1;
    end
    if (take) begin
      best_idx   <= rd_idx;
      best_entry <= rd_data;
      best_age   <= rd_age;
    end
  end

  // memory ports: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[idx];
    rd_vld  <= valid[idx];
    rd_idx  <= idx;
  end

  // result word
  always_ff @(posedge clk) begin
    if (res_load) begin
      status         <= res_next.status;
      selected_id    <= res_next.id;
      remaining_time <= res_next.rtime;
      new_priority   <= res_next.prio;
      finished       <= res_next.finished;
    end
  end

  `ASSERT_PROP(a_accept_busy, clk, rst, accept |=> busy,
               "busy not raised after accept")
  `ASSERT_PROP(a_done_src, clk, rst,
               done |-> $past(state == S_RUN_WB || state == S_LOAD_SCAN),
               "done without a finishing state")
  `ASSERT_PROP(a_zero_fields, clk, rst,
               (done && status != ST_RAN) |-> (selected_id == 8'd0 &&
                remaining_time == 8'd0 && new_priority == 8'sd0 && !finished),
               "non-run word with nonzero fields")
  `ASSERT_PROP(a_best_valid, clk, rst,
               (state == S_RUN_WB && best_found) |-> valid[best_idx],
               "chosen entry not valid")
  `ASSERT_NEVER(a_done_idle, clk, rst, done && busy, "done while busy")

endmodule
